// ===== src/lfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants for the lowest free room scheduler: beat
// payloads, field widths, parameter defaults and the sequencer states.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  localparam int MAX_ROOMS_DEF = 128;
  localparam int TIME_BITS_DEF = 48;

  localparam int IN_TIME_W  = 32;
  localparam int OUT_TIME_W = 48;
  localparam int ROOM_W     = 7;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 8;

  typedef logic [CFG_W-1:0] cfg_data_t;

  typedef struct packed {
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] end_time;
    logic                 last_job;
  } in_item_t;

  typedef struct packed {
    logic [ROOM_W-1:0]     room;
    logic [OUT_TIME_W-1:0] actual_start;
    logic [OUT_TIME_W-1:0] actual_end;
    logic [ROOM_W-1:0]     busiest_room;
    logic [COUNT_W-1:0]    busiest_count;
    logic                  final_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CNT_RD,
    ST_UPDATE
  } lfrs_state_t;

endpackage

// ===== src/lfrs_stream_if.sv =====
// ----------------------------------------------------------------------------
// lfrs_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface lfrs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/lowest_free_room_scheduler.sv =====
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler
// Places each job on the lowest free server, or else on the server that
// frees up first, and reports the running most-used server.
// ----------------------------------------------------------------------------
// A job scans k servers (k up to the room count n), one memory read per cycle,
// then reads the use count and, once the output register is free, updates.
// A new job is taken only in the idle state, after the previous one has been
// answered; the scan loop over the state memory's single read port paces it.
// Reset (and the end of every set): a sweep over all MAX_ROOMS entries zeroes the
// state memories; no job is taken meanwhile. On reset the room count goes to 1.
module lowest_free_room_scheduler #(
  parameter int MAX_ROOMS = lfrs_pkg::MAX_ROOMS_DEF,
  parameter int TIME_BITS = lfrs_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lfrs_stream_if.sink   cfg_chan,
  lfrs_stream_if.sink   in_chan,
  lfrs_stream_if.source out_chan
);
  import lfrs_pkg::*;

  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ROOMS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // State memories, one entry per server.
  logic [TIME_BITS-1:0] busy_mem [MAX_ROOMS];
  logic [COUNT_W-1:0]   cnt_mem  [MAX_ROOMS];

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [TIME_BITS-1:0] busy_wd;
  logic [COUNT_W-1:0]   cnt_wd;
  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_BITS-1:0] rd_busy_r;
  logic [COUNT_W-1:0]   rd_cnt_r;

  lfrs_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     iss_r, iss_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic [IDX_W-1:0]     last_idx_r, last_idx_nxt;
  logic [IN_TIME_W-1:0] start_r, start_nxt;
  logic [IN_TIME_W-1:0] dur_r, dur_nxt;
  logic                 last_r, last_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [TIME_BITS-1:0] min_r, min_nxt;
  logic [IDX_W-1:0]     min_idx_r, min_idx_nxt;
  logic [IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]     best_room_r, best_room_nxt;
  logic [COUNT_W-1:0]   best_count_r, best_count_nxt;
  logic [CFG_W-1:0]     num_rooms_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 load_out;
  logic                 busy_le;
  logic                 busy_lt;
  logic [TIME_BITS-1:0] begin_time;
  logic [TIME_BITS:0]   end_sum;
  logic [TIME_BITS-1:0] fin_time;
  logic [COUNT_W-1:0]   cnt_new;
  logic                 best_upd;

  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[mem_wa] <= busy_wd;
      cnt_mem[mem_wa]  <= cnt_wd;
    end
    rd_busy_r <= busy_mem[rd_addr];
    rd_cnt_r  <= cnt_mem[rd_addr];
  end

  // Shared compare unit of the scan, fed by the registered memory read.
  assign busy_le = rd_busy_r <= TIME_BITS'(start_r);
  assign busy_lt = (ev_idx_r == '0) || (rd_busy_r < min_r);

  // Update arithmetic; the sum carries one extra bit to detect overflow.
  assign begin_time = found_r ? TIME_BITS'(start_r) : min_r;
  assign end_sum    = {1'b0, begin_time} + (TIME_BITS + 1)'(dur_r);
  assign fin_time   = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
  assign cnt_new    = (rd_cnt_r == COUNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
  assign best_upd   = (cnt_new > best_count_r) ||
                      ((cnt_new == best_count_r) && (pick_r < best_room_r));

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    ev_vld_nxt     = ev_vld_r;
    ev_idx_nxt     = ev_idx_r;
    last_idx_nxt   = last_idx_r;
    start_nxt      = start_r;
    dur_nxt        = dur_r;
    last_nxt       = last_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    min_nxt        = min_r;
    min_idx_nxt    = min_idx_r;
    clr_cnt_nxt    = clr_cnt_r;
    best_room_nxt  = best_room_r;
    best_count_nxt = best_count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = pick_r;
    busy_wd        = fin_time;
    cnt_wd         = cnt_new;
    rd_addr        = pick_r;
    load_out       = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_wa         = clr_cnt_r;
        busy_wd        = '0;
        cnt_wd         = '0;
        best_room_nxt  = '0;
        best_count_nxt = '0;
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          start_nxt  = in_chan.data.start_time;
          dur_nxt    = (in_chan.data.end_time > in_chan.data.start_time) ?
                       in_chan.data.end_time - in_chan.data.start_time : '0;
          last_nxt   = in_chan.data.last_job;
          iss_nxt    = '0;
          ev_vld_nxt = 1'b0;
          found_nxt  = 1'b0;
          // A room count of zero acts as one, any above the memory depth as its depth.
          if (num_rooms_r == '0) begin
            last_idx_nxt = '0;
          end else if (32'(num_rooms_r) > MAX_ROOMS) begin
            last_idx_nxt = IDX_LAST;
          end else begin
            last_idx_nxt = IDX_W'(num_rooms_r - 1'b1);
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr    = iss_r;
        ev_vld_nxt = 1'b1;
        ev_idx_nxt = iss_r;
        if (iss_r != last_idx_r) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (ev_vld_r) begin
          if (busy_le) begin
            found_nxt = 1'b1;
            pick_nxt  = ev_idx_r;
            state_nxt = ST_CNT_RD;
          end else begin
            if (busy_lt) begin
              min_nxt     = rd_busy_r;
              min_idx_nxt = ev_idx_r;
            end
            if (ev_idx_r == last_idx_r) begin
              found_nxt = 1'b0;
              pick_nxt  = busy_lt ? ev_idx_r : min_idx_r;
              state_nxt = ST_CNT_RD;
            end
          end
        end
      end
      ST_CNT_RD: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Commit only when the output register is free or being emptied.
        if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          if (best_upd) begin
            best_room_nxt  = pick_r;
            best_count_nxt = cnt_new;
          end
          out_data_nxt.room          = ROOM_W'(pick_r);
          out_data_nxt.actual_start  = OUT_TIME_W'(begin_time);
          out_data_nxt.actual_end    = OUT_TIME_W'(fin_time);
          out_data_nxt.busiest_room  = best_upd ? ROOM_W'(pick_r) : ROOM_W'(best_room_r);
          out_data_nxt.busiest_count = best_upd ? cnt_new : best_count_r;
          out_data_nxt.final_res     = last_r;
          clr_cnt_nxt = '0;
          state_nxt   = last_r ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      num_rooms_r  <= CFG_W'(1);
      best_room_r  <= '0;
      best_count_r <= '0;
      ev_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      best_room_r  <= best_room_nxt;
      best_count_r <= best_count_nxt;
      ev_vld_r     <= ev_vld_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        num_rooms_r <= cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    ev_idx_r   <= ev_idx_nxt;
    last_idx_r <= last_idx_nxt;
    start_r    <= start_nxt;
    dur_r      <= dur_nxt;
    last_r     <= last_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    min_r      <= min_nxt;
    min_idx_r  <= min_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // The chosen server always lies within the rooms scanned for this job.
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (pick_r <= last_idx_r))
    else $error("picked server beyond the room count");

  // Outside the last job of a set, the busiest report never falls below the count just written.
  a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (state_r == ST_UPDATE) && !last_r |=> (best_count_r >= $past(cnt_new)))
    else $error("busiest count below a server's use count");

  // Answering the last job of a set starts a fresh clearing sweep.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && last_r |=> (state_r == ST_CLEAR) && (clr_cnt_r == '0))
    else $error("no clearing sweep after the last job of a set");

endmodule
